>>> sv/hgc_pkg.sv
package hgc_pkg;
  localparam int BUCKETS_DEF = 256;
  localparam int ENTRIES_DEF = 1024;
  localparam int CODE_W = 21;
  localparam int SIZE_W = 16;
  localparam int KEY_W = CODE_W + SIZE_W;
  localparam int META_W = 24;
  localparam int CAP_W = 11;
  localparam int IDX_OUT_W = 10;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_FLUSH  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;
endpackage

>>> sv/hashed_glyph_cache_fifo_evict_top.sv
// lookup reads the bucket head, then walks the chain; insert reads the slot it reuses,
// unlinks it if in use, links it into its bucket; flush and unused code skip to S_DONE
// throughput: one transaction at a time, busy high until its result strobe
// reset: synchronous active-low rst_n empties every bucket and slot, limit 1024
// the receiver cannot stall: each result is shown for one cycle on out_strobe
module hashed_glyph_cache_fifo_evict_top import hgc_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [CODE_W-1:0]    in_char_code,
  input  logic [SIZE_W-1:0]    in_glyph_size,
  input  logic [7:0]           in_glyph_width,
  input  logic [7:0]           in_glyph_height,
  input  logic signed [7:0]    in_baseline_offset,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAP_W-1:0]     cfg_capacity_limit,
  output logic                 out_strobe,
  output logic                 out_hit,
  output logic [IDX_OUT_W-1:0] out_entry_index,
  output logic [7:0]           out_found_width,
  output logic [7:0]           out_found_height,
  output logic signed [7:0]    out_found_offset,
  output logic                 out_evicted,
  output logic [IDX_OUT_W-1:0] out_evicted_index,
  output logic [CAP_W-1:0]     out_occupancy
);
  // capacity register, writes always taken
  logic [CAP_W-1:0] cap_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_capacity_limit;
    end
  end

  // chain walker and memories
  hgc_core #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_core (
    .clk, .rst_n, .start, .busy,
    .in_func, .in_char_code, .in_glyph_size, .in_glyph_width,
    .in_glyph_height, .in_baseline_offset, .cap_r,
    .out_strobe, .out_hit, .out_entry_index, .out_found_width,
    .out_found_height, .out_found_offset, .out_evicted,
    .out_evicted_index, .out_occupancy
  );
endmodule

>>> sv/hgc_core.sv
module hgc_core import hgc_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_func,
  input  logic [CODE_W-1:0]       in_char_code,
  input  logic [SIZE_W-1:0]       in_glyph_size,
  input  logic [7:0]              in_glyph_width,
  input  logic [7:0]              in_glyph_height,
  input  logic signed [7:0]       in_baseline_offset,
  input  logic [CAP_W-1:0]        cap_r,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic [IDX_OUT_W-1:0]    out_entry_index,
  output logic [7:0]              out_found_width,
  output logic [7:0]              out_found_height,
  output logic signed [7:0]       out_found_offset,
  output logic                    out_evicted,
  output logic [IDX_OUT_W-1:0]    out_evicted_index,
  output logic [CAP_W-1:0]        out_occupancy
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = EW + 1;            // link width, msb set means null
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NULL_L = {1'b1, {EW{1'b0}}};
  localparam logic [LW:0] STEP_MAX = (LW+1)'(ENTRIES);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HCLR  = 10'b0000000010,
    S_LHEAD = 10'b0000000100,
    S_LWALK = 10'b0000001000,
    S_EKEY  = 10'b0000010000,
    S_EHEAD = 10'b0000100000,
    S_EWALK = 10'b0001000000,
    S_IHEAD = 10'b0010000000,
    S_IHNXT = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } st_t;

  // memories
  logic [LW-1:0]     head_mem [BUCKETS];
  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [META_W-1:0] meta_mem [ENTRIES];
  logic [LW-1:0]     next_mem [ENTRIES];
  logic [LW-1:0] fill_r;                 // slots below this written since flush
  logic [BUCKETS-1:0] hvalid_r;          // bucket head written since flush

  st_t st_r, st_nxt;
  logic [1:0] func_r;
  logic [KEY_W-1:0] key_r;
  logic [META_W-1:0] meta_r;
  logic [EW-1:0] wslot_r, wslot_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW:0]   steps_r, steps_nxt;
  logic [EW-1:0] slot_r, slot_nxt;
  logic ev_r, ev_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt;
  logic [LW-1:0] slot_next_r, slot_next_nxt;  // next link of evicted slot

  // read ports, registered
  logic [BW-1:0] h_ra;
  logic [EW-1:0] e_ra;
  logic [LW-1:0] h_rd_q;
  logic h_vq;
  logic [KEY_W-1:0] k_rd;
  logic [META_W-1:0] m_rd;
  logic [LW-1:0] n_rd;
  logic v_rd;

  logic h_we; logic [BW-1:0] h_wa; logic [LW-1:0] h_wd;
  logic n_we; logic [EW-1:0] n_wa; logic [LW-1:0] n_wd;
  logic km_we;
  logic res_en;
  logic res_hit;
  logic [LW-1:0] h_rd;

  logic [CAP_W-1:0] lim;
  always_comb begin
    lim = cap_r;
    if (lim == '0) lim = CAP_W'(1);
    if ({1'b0, lim} > (CAP_W+1)'(ENTRIES)) lim = CAP_W'(ENTRIES);
  end

  assign h_rd = h_vq ? h_rd_q : NULL_L;
  assign busy = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    // head write to the bucket being read is passed through
    if (h_we && h_wa == h_ra) begin
      h_rd_q <= h_wd;
      h_vq   <= 1'b1;
    end else begin
      h_rd_q <= head_mem[h_ra];
      h_vq   <= hvalid_r[h_ra];
    end
    k_rd   <= key_mem[e_ra];
    m_rd   <= meta_mem[e_ra];
    n_rd   <= next_mem[e_ra];
    v_rd   <= ({1'b0, e_ra} < fill_r);
    if (h_we) head_mem[h_wa] <= h_wd;
    if (n_we) next_mem[n_wa] <= n_wd;
    if (km_we) begin
      key_mem[slot_r]  <= key_r;
      meta_mem[slot_r] <= meta_r;
    end
  end

  always_comb begin
    st_nxt = st_r; wslot_nxt = wslot_r; cnt_nxt = cnt_r; cur_nxt = cur_r;
    prev_nxt = prev_r; steps_nxt = steps_r; slot_nxt = slot_r; ev_nxt = ev_r;
    bkt_nxt = bkt_r; slot_next_nxt = slot_next_r;
    h_ra = bkt_r; e_ra = cur_r[EW-1:0];
    h_we = 1'b0; h_wa = bkt_r; h_wd = NULL_L;
    n_we = 1'b0; n_wa = slot_r; n_wd = NULL_L;
    km_we = 1'b0; res_en = 1'b0; res_hit = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          ev_nxt = 1'b0;
          steps_nxt = '0;
          bkt_nxt = BW'(in_char_code % BUCKETS);
          h_ra = BW'(in_char_code % BUCKETS);
          case (func_t'(in_func))
            FUNC_LOOKUP: st_nxt = S_LHEAD;
            FUNC_INSERT: begin
              slot_nxt = ({1'b0, wslot_r} >= (EW+1)'(lim)) ? '0 : wslot_r;
              cur_nxt = {1'b0, slot_nxt};
              e_ra = slot_nxt;
              st_nxt = S_EKEY;
            end
            FUNC_FLUSH: begin
              cnt_nxt = '0; wslot_nxt = '0;
              st_nxt = S_DONE;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_LHEAD: begin
        cur_nxt = h_rd;
        e_ra = h_rd[EW-1:0];
        st_nxt = h_rd[LW-1] ? S_DONE : S_LWALK;
      end
      S_LWALK: begin
        if (v_rd && k_rd == key_r) begin
          res_en = 1'b1; res_hit = 1'b1; st_nxt = S_IDLE;
        end else begin
          steps_nxt = steps_r + 1'b1;
          cur_nxt = n_rd;
          e_ra = n_rd[EW-1:0];
          if (n_rd[LW-1] || steps_nxt >= STEP_MAX) st_nxt = S_DONE;
        end
      end
      S_EKEY: begin
        // data of slot to reuse
        if (v_rd) begin
          ev_nxt = 1'b1;
          slot_next_nxt = n_rd;
          bkt_nxt = BW'(k_rd[CODE_W-1:0] % BUCKETS);
          h_ra = BW'(k_rd[CODE_W-1:0] % BUCKETS);
          cnt_nxt = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
          st_nxt = S_EHEAD;
        end else begin
          h_ra = BW'(key_r[CODE_W-1:0] % BUCKETS);
          bkt_nxt = h_ra;
          st_nxt = S_IHEAD;
        end
      end
      S_EHEAD: begin
        if (h_rd == {1'b0, slot_r}) begin
          h_we = 1'b1; h_wd = slot_next_r;
          h_ra = BW'(key_r[CODE_W-1:0] % BUCKETS);
          bkt_nxt = h_ra;
          st_nxt = S_IHEAD;
        end else if (h_rd[LW-1]) begin
          h_ra = BW'(key_r[CODE_W-1:0] % BUCKETS);
          bkt_nxt = h_ra;
          st_nxt = S_IHEAD;
        end else begin
          cur_nxt = h_rd; e_ra = h_rd[EW-1:0];
          st_nxt = S_EWALK;
        end
      end
      S_EWALK: begin
        // n_rd is next of cur
        if (n_rd == {1'b0, slot_r}) begin
          n_we = 1'b1; n_wa = cur_r[EW-1:0]; n_wd = slot_next_r;
          h_ra = BW'(key_r[CODE_W-1:0] % BUCKETS);
          bkt_nxt = h_ra;
          st_nxt = S_IHEAD;
        end else begin
          steps_nxt = steps_r + 1'b1;
          cur_nxt = n_rd; e_ra = n_rd[EW-1:0];
          if (n_rd[LW-1] || steps_nxt >= STEP_MAX) begin
            h_ra = BW'(key_r[CODE_W-1:0] % BUCKETS);
            bkt_nxt = h_ra;
            st_nxt = S_IHEAD;
          end
        end
      end
      S_IHEAD: begin
        km_we = 1'b1;
        if (h_rd[LW-1]) begin
          h_we = 1'b1; h_wd = {1'b0, slot_r};
          n_we = 1'b1; n_wa = slot_r; n_wd = NULL_L;
          st_nxt = S_DONE;
        end else begin
          cur_nxt = h_rd; e_ra = h_rd[EW-1:0];
          st_nxt = S_IHNXT;
        end
      end
      S_IHNXT: begin
        n_we = 1'b1; n_wa = cur_r[EW-1:0]; n_wd = {1'b0, slot_r};
        st_nxt = S_HCLR;  // slot's own next link follows in S_HCLR on the same write port
        prev_nxt = n_rd;
      end
      S_HCLR: begin
        n_we = 1'b1; n_wa = slot_r; n_wd = prev_r;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        res_en = 1'b1;
        st_nxt = S_IDLE;
        if (func_r == FUNC_INSERT) begin
          cnt_nxt = cnt_r + 1'b1;
          wslot_nxt = ({1'b0, slot_r} + 1'b1 >= (EW+1)'(lim)) ? '0 : slot_r + 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wslot_r <= '0; cnt_r <= '0; fill_r <= '0;
      hvalid_r <= '0; out_strobe <= 1'b0;
    end else begin
      st_r <= st_nxt; wslot_r <= wslot_nxt; cnt_r <= cnt_nxt;
      out_strobe <= res_en;
      if (h_we) hvalid_r[h_wa] <= 1'b1;
      if (st_r == S_IDLE && start && func_t'(in_func) == FUNC_FLUSH) begin
        fill_r <= '0; hvalid_r <= '0;
      end
      // slots fill in ring order from zero, so the written set is a prefix
      if (st_r == S_DONE && func_r == FUNC_INSERT && {1'b0, slot_r} >= fill_r)
        fill_r <= {1'b0, slot_r} + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; prev_r <= prev_nxt; steps_r <= steps_nxt;
    slot_r <= slot_nxt; ev_r <= ev_nxt; bkt_r <= bkt_nxt;
    slot_next_r <= slot_next_nxt;
    if (st_r == S_IDLE && start) begin
      func_r <= in_func;
      key_r  <= {in_glyph_size, in_char_code};
      meta_r <= {in_baseline_offset, in_glyph_height, in_glyph_width};
    end
    if (res_en) begin
      out_hit <= res_hit;
      out_entry_index <= '0; out_found_width <= '0; out_found_height <= '0;
      out_found_offset <= '0; out_evicted <= 1'b0; out_evicted_index <= '0;
      out_occupancy <= CAP_W'(cnt_nxt);
      if (res_hit) begin
        out_entry_index <= IDX_OUT_W'(cur_r[EW-1:0]);
        out_found_width <= m_rd[7:0];
        out_found_height <= m_rd[15:8];
        out_found_offset <= m_rd[23:16];
      end else if (func_r == FUNC_INSERT) begin
        out_entry_index <= IDX_OUT_W'(slot_r);
        out_evicted <= ev_r;
        out_evicted_index <= ev_r ? IDX_OUT_W'(slot_r) : '0;
      end
    end
  end
endmodule

>>> sim/tb.sv
module tb;
  import hgc_pkg::*;

  localparam int NB = BUCKETS_DEF;
  localparam int NE = ENTRIES_DEF;
  localparam int NULL_LINK = NE;
  // cycles with no transaction before the run is declared hung
  localparam int HANG_LIMIT = 40000;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] idx;
    logic [7:0]           wid;
    logic [7:0]           hgt;
    logic signed [7:0]    off;
    logic                 ev;
    logic [IDX_OUT_W-1:0] ev_idx;
    logic [CAP_W-1:0]     occ;
  } glyph_res_t;

  typedef struct {
    func_t             f;
    logic [CODE_W-1:0] code;
    logic [SIZE_W-1:0] gsize;
    logic [7:0]        wid;
    logic [7:0]        hgt;
    logic signed [7:0] off;
    bit                typed;
    glyph_res_t        res;
  } dir_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [CODE_W-1:0] in_char_code = '0;
  logic [SIZE_W-1:0] in_glyph_size = '0;
  logic [7:0] in_glyph_width = '0;
  logic [7:0] in_glyph_height = '0;
  logic signed [7:0] in_baseline_offset = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_capacity_limit = '0;
  logic out_strobe;
  logic out_hit;
  logic [IDX_OUT_W-1:0] out_entry_index;
  logic [7:0] out_found_width;
  logic [7:0] out_found_height;
  logic signed [7:0] out_found_offset;
  logic out_evicted;
  logic [IDX_OUT_W-1:0] out_evicted_index;
  logic [CAP_W-1:0] out_occupancy;

  always #4 clk = ~clk;

  hashed_glyph_cache_fifo_evict_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_char_code(in_char_code), .in_glyph_size(in_glyph_size),
    .in_glyph_width(in_glyph_width), .in_glyph_height(in_glyph_height),
    .in_baseline_offset(in_baseline_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_capacity_limit(cfg_capacity_limit),
    .out_strobe(out_strobe), .out_hit(out_hit), .out_entry_index(out_entry_index),
    .out_found_width(out_found_width), .out_found_height(out_found_height),
    .out_found_offset(out_found_offset), .out_evicted(out_evicted),
    .out_evicted_index(out_evicted_index), .out_occupancy(out_occupancy)
  );

  // shadow copy of the cache contents
  int               sh_head [NB];
  logic [KEY_W-1:0] sh_key  [NE];
  logic [META_W-1:0] sh_meta [NE];
  int               sh_next [NE];
  bit               sh_valid[NE];
  int               sh_wslot;
  int               sh_count;
  int               sh_cap;

  glyph_res_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;

  // pool of keys reused so that lookups hit and chains grow
  logic [CODE_W-1:0] pool_code[24];
  logic [SIZE_W-1:0] pool_size[24];

  function automatic glyph_res_t mk(bit h, int i, int w, int ht, int o, bit e, int ei, int oc);
    glyph_res_t r;
    r.hit = h; r.idx = IDX_OUT_W'(i); r.wid = 8'(w); r.hgt = 8'(ht); r.off = 8'(o);
    r.ev = e; r.ev_idx = IDX_OUT_W'(ei); r.occ = CAP_W'(oc);
    return r;
  endfunction

  function automatic void cache_clear();
    for (int i = 0; i < NB; i++) sh_head[i] = NULL_LINK;
    for (int i = 0; i < NE; i++) begin
      sh_valid[i] = 0;
      sh_next[i] = NULL_LINK;
    end
    sh_count = 0;
    sh_wslot = 0;
  endfunction

  function automatic void chain_remove(int slot);
    int b;
    int cur;
    int steps;
    b = sh_key[slot][CODE_W-1:0] % NB;
    cur = sh_head[b];
    steps = 0;
    if (cur == slot) begin
      sh_head[b] = sh_next[slot];
      return;
    end
    while (cur < NE && steps < NE) begin
      if (sh_next[cur] == slot) begin
        sh_next[cur] = sh_next[slot];
        return;
      end
      cur = sh_next[cur];
      steps++;
    end
  endfunction

  function automatic glyph_res_t cache_predict(func_t f, logic [CODE_W-1:0] code,
      logic [SIZE_W-1:0] gsize, logic [7:0] w, logic [7:0] h, logic [7:0] o);
    glyph_res_t r;
    logic [KEY_W-1:0] key;
    int b;
    int cur;
    int steps;
    int lim;
    int slot;
    r = '0;
    key = {gsize, code};
    b = code % NB;
    case (f)
      FUNC_LOOKUP: begin
        cur = sh_head[b];
        steps = 0;
        while (cur < NE && steps < NE) begin
          if (sh_valid[cur] && sh_key[cur] == key) begin
            r.hit = 1;
            r.idx = IDX_OUT_W'(cur);
            {r.off, r.hgt, r.wid} = sh_meta[cur];
            break;
          end
          cur = sh_next[cur];
          steps++;
        end
      end
      FUNC_INSERT: begin
        lim = (sh_cap == 0) ? 1 : (sh_cap > NE ? NE : sh_cap);
        if (sh_wslot >= lim) sh_wslot = 0;
        slot = sh_wslot;
        if (sh_valid[slot]) begin
          chain_remove(slot);
          sh_valid[slot] = 0;
          if (sh_count > 0) sh_count--;
          r.ev = 1;
          r.ev_idx = IDX_OUT_W'(slot);
        end
        sh_key[slot] = key;
        sh_meta[slot] = {o, h, w};
        if (sh_head[b] >= NE) begin
          sh_next[slot] = NULL_LINK;
          sh_head[b] = slot;
        end else begin
          sh_next[slot] = sh_next[sh_head[b]];
          sh_next[sh_head[b]] = slot;
        end
        sh_valid[slot] = 1;
        sh_count++;
        sh_wslot = (slot + 1 >= lim) ? 0 : slot + 1;
        r.idx = IDX_OUT_W'(slot);
      end
      FUNC_FLUSH: cache_clear();
      default: ;
    endcase
    r.occ = CAP_W'(sh_count);
    return r;
  endfunction

  // one command transaction, after an optional random idle gap
  task automatic send_cmd(func_t f, logic [CODE_W-1:0] code, logic [SIZE_W-1:0] gsize,
      logic [7:0] w, logic [7:0] h, logic signed [7:0] o, bit typed, glyph_res_t typed_res);
    int gap;
    glyph_res_t r;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_func <= f;
    in_char_code <= code;
    in_glyph_size <= gsize;
    in_glyph_width <= w;
    in_glyph_height <= h;
    in_baseline_offset <= o;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    r = cache_predict(f, code, gsize, w, h, o);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    start <= 0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // capacity register write, only with the cache idle
  task automatic write_cap(int cap);
    wait_drained();
    cfg_valid <= 1;
    cfg_capacity_limit <= CAP_W'(cap);
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 0;
    sh_cap = cap;
  endtask

  task automatic refill_pool();
    logic [CODE_W-1:0] base;
    base = CODE_W'($urandom_range(0, 32'h10FFFF));
    for (int i = 0; i < 24; i++) begin
      // a third share one bucket, the rest spread over codes 0 to 10FFFF hex
      if (i < 8) pool_code[i] = CODE_W'((base % NB) + NB * $urandom_range(0, 32'h10FF));
      else pool_code[i] = CODE_W'($urandom_range(0, 32'h10FFFF));
      pool_size[i] = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 16'hFFFF))
                                                  : SIZE_W'($urandom_range(8, 12));
    end
  endtask

  task automatic random_phase(int n);
    int k;
    int sel;
    func_t f;
    glyph_res_t nil;
    nil = '0;
    refill_pool();
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 23);
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        // lookup followed by insert of the same key, the normal miss path
        send_cmd(FUNC_LOOKUP, pool_code[k], pool_size[k], 8'($urandom), 8'($urandom),
                 8'($urandom), 0, nil);
        send_cmd(FUNC_INSERT, pool_code[k], pool_size[k], 8'($urandom), 8'($urandom),
                 8'($urandom), 0, nil);
        i++;
      end else begin
        if (sel < 60) f = FUNC_LOOKUP;
        else if (sel < 92) f = FUNC_INSERT;
        else if (sel < 96) f = FUNC_FLUSH;
        else f = FUNC_NONE;
        if ($urandom_range(0, 9) == 0)
          send_cmd(f, CODE_W'($urandom_range(0, 32'h10FFFF)), SIZE_W'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 0, nil);
        else
          send_cmd(f, pool_code[k], pool_size[k], 8'($urandom), 8'($urandom),
                   8'($urandom), 0, nil);
      end
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker, results cannot be held off so every strobe is consumed
  always @(posedge clk) begin
    glyph_res_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("hit", e.hit, out_hit);
        check_field("entry_index", e.idx, out_entry_index);
        check_field("found_width", e.wid, out_found_width);
        check_field("found_height", e.hgt, out_found_height);
        check_field("found_offset", e.off, out_found_offset);
        check_field("evicted", e.ev, out_evicted);
        check_field("evicted_index", e.ev_idx, out_evicted_index);
        check_field("occupancy", e.occ, out_occupancy);
      end
    end
  end

  // watchdog on transaction activity
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  dir_row_t dir_tab[18];

  initial begin
    // directed rows, reset state with limit 1024; typed rows need no predictor
    dir_tab[0]  = '{FUNC_LOOKUP, 21'h0, 16'h0, 8'd0, 8'd0, 8'sd0, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 0)};
    dir_tab[1]  = '{FUNC_INSERT, 21'h10FFFF, 16'hFFFF, 8'd255, 8'd255, -8'sd128, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 1)};
    dir_tab[2]  = '{FUNC_LOOKUP, 21'h10FFFF, 16'hFFFF, 8'd0, 8'd0, 8'sd0, 1,
                    mk(1, 0, 255, 255, -128, 0, 0, 1)};
    dir_tab[3]  = '{FUNC_INSERT, 21'h0, 16'h0, 8'd0, 8'd0, 8'sd127, 1,
                    mk(0, 1, 0, 0, 0, 0, 0, 2)};
    // two more in bucket 0, linked after the head
    dir_tab[4]  = '{FUNC_INSERT, 21'h100, 16'h0, 8'd1, 8'd2, 8'sd3, 1,
                    mk(0, 2, 0, 0, 0, 0, 0, 3)};
    dir_tab[5]  = '{FUNC_INSERT, 21'h200, 16'h0, 8'd4, 8'd5, 8'sd6, 1,
                    mk(0, 3, 0, 0, 0, 0, 0, 4)};
    dir_tab[6]  = '{FUNC_LOOKUP, 21'h100, 16'h0, 8'd0, 8'd0, 8'sd0, 1,
                    mk(1, 2, 1, 2, 3, 0, 0, 4)};
    dir_tab[7]  = '{FUNC_LOOKUP, 21'h200, 16'h0, 8'd0, 8'd0, 8'sd0, 1,
                    mk(1, 3, 4, 5, 6, 0, 0, 4)};
    // miss at the end of a full chain walk
    dir_tab[8]  = '{FUNC_LOOKUP, 21'h300, 16'h0, 8'd0, 8'd0, 8'sd0, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 4)};
    // same code, other size
    dir_tab[9]  = '{FUNC_LOOKUP, 21'h0, 16'h1, 8'd0, 8'd0, 8'sd0, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 4)};
    // duplicate key insert, then lookup picks the first in chain order
    dir_tab[10] = '{FUNC_INSERT, 21'h0, 16'h0, 8'd9, 8'd9, 8'sd9, 0, '0};
    dir_tab[11] = '{FUNC_LOOKUP, 21'h0, 16'h0, 8'd0, 8'd0, 8'sd0, 0, '0};
    dir_tab[12] = '{FUNC_NONE, 21'h0FFFFF, 16'hFFFF, 8'd255, 8'd255, -8'sd1, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 5)};
    dir_tab[13] = '{FUNC_FLUSH, 21'h0, 16'h0, 8'd0, 8'd0, 8'sd0, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 0)};
    dir_tab[14] = '{FUNC_LOOKUP, 21'h10FFFF, 16'hFFFF, 8'd0, 8'd0, 8'sd0, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 0)};
    dir_tab[15] = '{FUNC_INSERT, 21'h0FFFFF, 16'h5555, 8'hAA, 8'h55, -8'sd1, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 1)};
    dir_tab[16] = '{FUNC_LOOKUP, 21'h0FFFFF, 16'h5555, 8'd0, 8'd0, 8'sd0, 1,
                    mk(1, 0, 8'hAA, 8'h55, -1, 0, 0, 1)};
    dir_tab[17] = '{FUNC_FLUSH, 21'h0, 16'h0, 8'd0, 8'd0, 8'sd0, 1,
                    mk(0, 0, 0, 0, 0, 0, 0, 0)};

    cache_clear();
    sh_cap = CAP_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_cmd(dir_tab[i].f, dir_tab[i].code, dir_tab[i].gsize, dir_tab[i].wid,
               dir_tab[i].hgt, dir_tab[i].off, dir_tab[i].typed, dir_tab[i].res);

    // reset limit first, then small, degenerate and oversized limits
    random_phase(100);
    write_cap(1);
    random_phase(100);
    write_cap(0);
    random_phase(90);
    write_cap(2);
    random_phase(100);
    write_cap(3);
    random_phase(100);
    write_cap(2047);
    random_phase(100);
    write_cap(16);
    random_phase(70);
    // shrink without a flush: slots past the new limit linger
    write_cap(5);
    random_phase(100);
    write_cap($urandom_range(4, 40));
    random_phase(70);

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

>>> hashed_glyph_cache_fifo_evict_top.f
sv/hgc_pkg.sv
sv/hgc_core.sv
sv/hashed_glyph_cache_fifo_evict_top.sv
sim/tb.sv
